>>> rtl/assert_macros.svh
// assertion helpers for the step engine checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/dla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dla_pkg;
  typedef enum logic [1:0] {
    ACT_PLANT = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_SLOT = 2'd2,
    ST_OFF     = 2'd3
  } status_t;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
endpackage
`default_nettype wire

>>> rtl/dla_particle_step_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Command-style diffusion-limited aggregation engine. Raise start with an
// action while busy is low; exactly one result appears later for one cycle
// with done high, and the receiver cannot stall it. Plant, add and an idle
// action go from the request to write-back and then the result state, with
// done high in the result state. A step of a live particle does one
// particle memory read, then nine crystal memory reads one per cycle
// (single read port), a last state to take in the last read, then write-back
// and the result state. A step of a slot that is not live goes from the
// particle read straight to write-back. After reset a clearing pass sweeps
// all MAX_SIDE*MAX_SIDE crystal memory cells, with busy high; configuration
// writes are taken always.
module dla_particle_step_engine_top #(
  parameter int MAX_SIDE      = 256,
  parameter int MAX_PARTICLES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [9:0]  slot,
  input  wire logic [7:0]  pos_x,
  input  wire logic [7:0]  pos_y,
  input  wire logic signed [1:0] step_x,
  input  wire logic signed [1:0] step_y,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [8:0]  cfg_data,
  output logic             done,
  output logic [7:0]       new_x,
  output logic [7:0]       new_y,
  output logic             stuck,
  output logic [10:0]      live_count,
  output logic [1:0]       status
);
  localparam int CB = $clog2(MAX_SIDE);
  localparam int AB = 2 * CB;
  localparam int PB = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int NB = $clog2(MAX_PARTICLES + 1);
  localparam int SB = CB + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PREAD, S_SCAN, S_LAST, S_WRITE, S_DONE
  } state_t;

  state_t           state;
  logic [8:0]       grid_width, grid_height;
  logic [NB-1:0]    count;
  logic [AB:0]      clr_addr;
  logic [1:0]       act;
  logic [9:0]       slot_r;
  logic [7:0]       px, py;
  logic [1:0]       mx, my;
  logic [SB-1:0]    wv, hv;
  logic [CB-1:0]    nx, ny;
  logic [3:0]       nb;
  logic             hit, pend;
  logic             pend_ok;
  logic [PB-1:0]    last_slot;

  // crystal memory
  logic             cmap [MAX_SIDE*MAX_SIDE];
  logic             c_we, c_wd, c_rd;
  logic [AB-1:0]    c_wa, c_ra;
  always_ff @(posedge clk) begin
    if (c_we) cmap[c_wa] <= c_wd;
    c_rd <= cmap[c_ra];
  end

  // particle memory, {y, x}
  logic [2*CB-1:0]  plist [MAX_PARTICLES];
  logic             p_we;
  logic [PB-1:0]    p_wa, p_ra;
  logic [2*CB-1:0]  p_wd, p_rd;
  always_ff @(posedge clk) begin
    if (p_we) plist[p_wa] <= p_wd;
    p_rd <= plist[p_ra];
  end

  // effective sizes
  always_comb begin
    wv = (grid_width == 9'd0) ? SB'(1) :
         ({23'd0, grid_width} > MAX_SIDE) ? SB'(MAX_SIDE) : SB'(grid_width);
    hv = (grid_height == 9'd0) ? SB'(1) :
         ({23'd0, grid_height} > MAX_SIDE) ? SB'(MAX_SIDE) : SB'(grid_height);
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // clamped new position from memory read
  logic [CB+1:0] sx, sy;
  logic [CB-1:0] cx, cy;
  always_comb begin
    sx = {2'b00, p_rd[CB-1:0]} + ((mx == 2'b01) ? (CB+2)'(1) :
         (mx == 2'b00) ? (CB+2)'(0) : {(CB+2){1'b1}});
    sy = {2'b00, p_rd[2*CB-1:CB]} + ((my == 2'b01) ? (CB+2)'(1) :
         (my == 2'b00) ? (CB+2)'(0) : {(CB+2){1'b1}});
    if (sx[CB+1]) cx = '0;
    else if (sx >= (CB+2)'(wv)) cx = CB'(wv - SB'(1));
    else cx = sx[CB-1:0];
    if (sy[CB+1]) cy = '0;
    else if (sy >= (CB+2)'(hv)) cy = CB'(hv - SB'(1));
    else cy = sy[CB-1:0];
  end

  // column and row offset of neighbour index nb
  logic [1:0] ofs_x, ofs_y;
  always_comb begin
    unique case (nb)
      4'd0:    begin ofs_x = 2'd0; ofs_y = 2'd0; end
      4'd1:    begin ofs_x = 2'd1; ofs_y = 2'd0; end
      4'd2:    begin ofs_x = 2'd2; ofs_y = 2'd0; end
      4'd3:    begin ofs_x = 2'd0; ofs_y = 2'd1; end
      4'd4:    begin ofs_x = 2'd1; ofs_y = 2'd1; end
      4'd5:    begin ofs_x = 2'd2; ofs_y = 2'd1; end
      4'd6:    begin ofs_x = 2'd0; ofs_y = 2'd2; end
      4'd7:    begin ofs_x = 2'd1; ofs_y = 2'd2; end
      4'd8:    begin ofs_x = 2'd2; ofs_y = 2'd2; end
      default: begin ofs_x = 2'd0; ofs_y = 2'd0; end
    endcase
  end

  // neighbour address for index nb
  logic [CB+1:0] qx, qy;
  logic          q_ok;
  always_comb begin
    qx = {2'b00, nx} + (CB+2)'(ofs_x) - (CB+2)'(1);
    qy = {2'b00, ny} + (CB+2)'(ofs_y) - (CB+2)'(1);
    q_ok = !qx[CB+1] && !qy[CB+1] && (qx < (CB+2)'(wv)) && (qy < (CB+2)'(hv));
  end

  logic on_grid;
  assign on_grid = ({1'b0, px} < 9'(wv)) && ({1'b0, py} < 9'(hv));
  assign last_slot = PB'(count - NB'(1));

  // memory ports
  always_comb begin
    c_we = 1'b0; c_wd = 1'b1; c_wa = {ny, nx}; c_ra = {qy[CB-1:0], qx[CB-1:0]};
    p_we = 1'b0; p_wa = PB'(slot_r); p_wd = {ny, nx}; p_ra = PB'(slot_r);
    unique case (state)
      S_CLEAR: begin c_we = 1'b1; c_wd = 1'b0; c_wa = clr_addr[AB-1:0]; end
      S_IDLE:  p_ra = PB'(slot);
      S_SCAN, S_LAST: p_ra = last_slot;
      S_WRITE: begin
        if (act == dla_pkg::ACT_PLANT && on_grid) begin
          c_we = 1'b1; c_wa = {CB'(py), CB'(px)};
        end else if (act == dla_pkg::ACT_ADD && NB'(count) < NB'(MAX_PARTICLES) && on_grid)
        begin
          p_we = 1'b1; p_wa = PB'(count); p_wd = {CB'(py), CB'(px)};
        end else if (act == dla_pkg::ACT_STEP && pend) begin
          p_we = 1'b1;
          if (hit) begin c_we = 1'b1; p_wd = p_rd; end
        end
      end
      default: ;
    endcase
  end

  // result fields and list length for the write-back cycle
  logic [7:0]    new_x_next, new_y_next;
  logic          stuck_next;
  logic [1:0]    status_next;
  logic [NB-1:0] count_next;
  always_comb begin
    new_x_next = 8'd0; new_y_next = 8'd0; stuck_next = 1'b0;
    status_next = dla_pkg::ST_OK; count_next = count;
    unique case (act)
      dla_pkg::ACT_PLANT: begin
        new_x_next = px; new_y_next = py;
        if (!on_grid) status_next = dla_pkg::ST_OFF;
      end
      dla_pkg::ACT_ADD: begin
        new_x_next = px; new_y_next = py;
        if (!(NB'(count) < NB'(MAX_PARTICLES))) status_next = dla_pkg::ST_FULL;
        else if (!on_grid) status_next = dla_pkg::ST_OFF;
        else count_next = count + NB'(1);
      end
      dla_pkg::ACT_STEP: begin
        if (!pend) status_next = dla_pkg::ST_NO_SLOT;
        else begin
          new_x_next = 8'(nx); new_y_next = 8'(ny);
          if (hit) begin stuck_next = 1'b1; count_next = count - NB'(1); end
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_addr <= '0; count <= '0; done <= 1'b0;
      grid_width <= 9'd256; grid_height <= 9'd256;
    end else begin
      done <= (state == S_WRITE);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dla_pkg::REG_WIDTH) grid_width <= cfg_data;
        else grid_height <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (AB+1)'(MAX_SIDE*MAX_SIDE - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          act <= action; slot_r <= slot; px <= pos_x; py <= pos_y;
          mx <= step_x; my <= step_y; hit <= 1'b0; nb <= '0;
          pend <= ({22'd0, slot} < 32'(count)) && ({22'd0, slot} < MAX_PARTICLES);
          state <= (action == dla_pkg::ACT_STEP) ? S_PREAD : S_WRITE;
        end
        S_PREAD: begin
          if (!pend) state <= S_WRITE;
          else begin
            nx <= cx; ny <= cy; state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one neighbour read per cycle; result checked next cycle
          if (nb != 4'd0 && pend_ok) hit <= hit | c_rd;
          pend_ok <= q_ok;
          nb <= nb + 4'd1;
          if (nb == 4'd8) state <= S_LAST;
        end
        S_LAST: begin
          if (pend_ok) hit <= hit | c_rd;
          state <= S_WRITE;
        end
        S_WRITE: begin
          new_x <= new_x_next; new_y <= new_y_next; stuck <= stuck_next;
          status <= status_next; count <= count_next;
          state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign live_count = 11'(count);
endmodule
`default_nettype wire

>>> rtl/dla_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dla_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        stuck,
  input wire logic [1:0]  status,
  input wire logic [10:0] live_count
);
  // a request is always followed by busy
  `CHK_NEXT(a_busy, clk, rst, start && !busy, busy, "request did not raise busy")
  // results only come while busy
  `CHK_IMPL(a_done, clk, rst, done, busy, "result outside a request")
  // frozen particle means ok status
  `CHK_IMPL(a_stuck, clk, rst, done && stuck, status == dla_pkg::ST_OK, "stuck with error status")
  // count never exceeds the list
  `CHK_IMPL(a_cnt, clk, rst, 1'b1, live_count <= 11'd1024, "count out of range")
endmodule
bind dla_particle_step_engine_top dla_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .stuck(stuck), .status(status), .live_count(live_count)
);
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  localparam int SIDE      = 256;
  localparam int PARTS     = 1024;
  localparam int CYC_LIMIT = 1000000;

  typedef struct packed {
    dla_pkg::action_t act;
    logic [9:0] slot;
    logic [7:0] px;
    logic [7:0] py;
    logic [1:0] sx;
    logic [1:0] sy;
  } request_t;

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic        stuck;
    logic [10:0] count;
    dla_pkg::status_t status;
  } outcome_t;

  typedef struct packed {
    logic       is_cfg;
    logic       cfg_reg;
    logic [8:0] cfg_val;
    request_t   req;
    logic       typed;
    outcome_t   want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = '0;
  logic [9:0] slot = '0;
  logic [7:0] pos_x = '0;
  logic [7:0] pos_y = '0;
  logic signed [1:0] step_x = '0;
  logic signed [1:0] step_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;
  logic done;
  logic [7:0] new_x;
  logic [7:0] new_y;
  logic stuck;
  logic [10:0] live_count;
  logic [1:0] status;

  dla_particle_step_engine_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .slot(slot),
    .pos_x(pos_x), .pos_y(pos_y), .step_x(step_x), .step_y(step_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .new_x(new_x), .new_y(new_y), .stuck(stuck),
    .live_count(live_count), .status(status)
  );

  always #1 clk = ~clk;

  // mirror of the grid, particle list and size registers
  bit         crystal [SIDE*SIDE];
  logic [7:0] walker_x [PARTS];
  logic [7:0] walker_y [PARTS];
  int         walkers;
  logic [8:0] width_reg;
  logic [8:0] height_reg;

  outcome_t pending_results[$];
  row_t     directed_rows[$];
  int       errors;
  int       cycles;
  bit       calm;

  function automatic int span(logic [8:0] v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return v;
  endfunction

  function automatic int move_of(logic [1:0] code);
    if (code == 2'b01) return 1;
    if (code == 2'b00) return 0;
    return -1;
  endfunction

  // apply one request to the mirror and return its outcome
  function automatic outcome_t aggregate(request_t r);
    outcome_t o;
    int w, h, nx, ny, cx, cy, last;
    bit hit;
    w = span(width_reg);
    h = span(height_reg);
    o = '0;
    o.status = dla_pkg::ST_OK;
    case (r.act)
      dla_pkg::ACT_PLANT: begin
        o.x = r.px;
        o.y = r.py;
        if (r.px >= w || r.py >= h) o.status = dla_pkg::ST_OFF;
        else crystal[r.py*SIDE + r.px] = 1'b1;
      end
      dla_pkg::ACT_ADD: begin
        o.x = r.px;
        o.y = r.py;
        if (walkers >= PARTS) o.status = dla_pkg::ST_FULL;
        else if (r.px >= w || r.py >= h) o.status = dla_pkg::ST_OFF;
        else begin
          walker_x[walkers] = r.px;
          walker_y[walkers] = r.py;
          walkers++;
        end
      end
      dla_pkg::ACT_STEP: begin
        if (r.slot >= walkers) o.status = dla_pkg::ST_NO_SLOT;
        else begin
          nx = int'(walker_x[r.slot]) + move_of(r.sx);
          ny = int'(walker_y[r.slot]) + move_of(r.sy);
          if (nx < 0) nx = 0;
          if (nx > w - 1) nx = w - 1;
          if (ny < 0) ny = 0;
          if (ny > h - 1) ny = h - 1;
          hit = 1'b0;
          for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
              cx = nx + dx;
              cy = ny + dy;
              if (cx >= 0 && cx < w && cy >= 0 && cy < h && crystal[cy*SIDE + cx])
                hit = 1'b1;
            end
          end
          o.x = 8'(nx);
          o.y = 8'(ny);
          if (hit) begin
            last = walkers - 1;
            crystal[ny*SIDE + nx] = 1'b1;
            walker_x[r.slot] = walker_x[last];
            walker_y[r.slot] = walker_y[last];
            walkers = last;
            o.stuck = 1'b1;
          end else begin
            walker_x[r.slot] = 8'(nx);
            walker_y[r.slot] = 8'(ny);
          end
        end
      end
      default: ;
    endcase
    o.count = 11'(walkers);
    return o;
  endfunction

  function automatic request_t mk(dla_pkg::action_t a, int sl, int x, int y,
                                  logic [1:0] sx, logic [1:0] sy);
    request_t r;
    r.act = a;
    r.slot = 10'(sl);
    r.px = 8'(x);
    r.py = 8'(y);
    r.sx = sx;
    r.sy = sy;
    return r;
  endfunction

  function automatic void push_row(request_t r, bit typed, outcome_t want);
    row_t t;
    t = '0;
    t.req = r;
    t.typed = typed;
    t.want = want;
    directed_rows.push_back(t);
  endfunction

  function automatic void push_cfg(logic idx, logic [8:0] val);
    row_t t;
    t = '0;
    t.is_cfg = 1'b1;
    t.cfg_reg = idx;
    t.cfg_val = val;
    directed_rows.push_back(t);
  endfunction

  function automatic outcome_t oc(int x, int y, int s, int n, dla_pkg::status_t st);
    outcome_t o;
    o.x = 8'(x);
    o.y = 8'(y);
    o.stuck = 1'(s);
    o.count = 11'(n);
    o.status = st;
    return o;
  endfunction

  // drive one request and wait for it to be taken
  task automatic issue(request_t r, bit typed, outcome_t want);
    outcome_t o;
    action <= r.act;
    slot <= r.slot;
    pos_x <= r.px;
    pos_y <= r.py;
    step_x <= r.sx;
    step_y <= r.sy;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    o = aggregate(r);
    pending_results.push_back(typed ? want : o);
  endtask

  // let all results come back, then allow for block latency
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == dla_pkg::REG_WIDTH) width_reg = val;
    else height_reg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic maybe_idle();
    int n;
    if (!calm && $urandom_range(3) == 0) begin
      n = $urandom_range(11, 1);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // random request, most often a step of a live particle; adds and plants mostly inside the grid
  function automatic request_t pick_request();
    request_t r;
    int w, h, k;
    w = span(width_reg);
    h = span(height_reg);
    r.slot = 10'($urandom_range(1023));
    r.px = 8'($urandom_range(255));
    r.py = 8'($urandom_range(255));
    r.sx = 2'($urandom_range(3));
    r.sy = 2'($urandom_range(3));
    k = $urandom_range(99);
    if (k < 45 && walkers > 0) begin
      r.act = dla_pkg::ACT_STEP;
      r.slot = 10'($urandom_range(walkers - 1));
    end else if (k < 52) begin
      r.act = dla_pkg::ACT_STEP;
    end else if (k < 75) begin
      r.act = dla_pkg::ACT_ADD;
      if ($urandom_range(9) != 0) begin
        r.px = 8'($urandom_range(w - 1));
        r.py = 8'($urandom_range(h - 1));
      end
    end else if (k < 95) begin
      r.act = dla_pkg::ACT_PLANT;
      if ($urandom_range(5) != 0) begin
        r.px = 8'($urandom_range(w - 1));
        r.py = 8'($urandom_range(h - 1));
      end
    end else begin
      r.act = dla_pkg::ACT_NONE;
    end
    return r;
  endfunction

  task automatic run_phase(logic [8:0] w, logic [8:0] h, int n);
    drain();
    write_reg(dla_pkg::REG_WIDTH, w);
    write_reg(dla_pkg::REG_HEIGHT, h);
    for (int i = 0; i < n; i++) begin
      issue(pick_request(), 1'b0, '0);
      maybe_idle();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, new_x, new_y);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (new_x !== e.x) begin
          $display("%0t: new_x expected %0d actual %0d", $time, e.x, new_x);
          errors++;
        end
        if (new_y !== e.y) begin
          $display("%0t: new_y expected %0d actual %0d", $time, e.y, new_y);
          errors++;
        end
        if (stuck !== e.stuck) begin
          $display("%0t: stuck expected %0d actual %0d", $time, e.stuck, stuck);
          errors++;
        end
        if (live_count !== e.count) begin
          $display("%0t: live_count expected %0d actual %0d", $time, e.count, live_count);
          errors++;
        end
        if (status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    request_t r;
    errors = 0;
    cycles = 0;
    walkers = 0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, extremes, unused action, clamping, freezing
    push_row(mk(dla_pkg::ACT_STEP, 0, 0, 0, 2'b00, 2'b00), 1,
             oc(0, 0, 0, 0, dla_pkg::ST_NO_SLOT));
    push_row(mk(dla_pkg::ACT_NONE, 1023, 255, 255, 2'b11, 2'b11), 1,
             oc(0, 0, 0, 0, dla_pkg::ST_OK));
    push_row(mk(dla_pkg::ACT_PLANT, 0, 255, 255, 2'b00, 2'b00), 1,
             oc(255, 255, 0, 0, dla_pkg::ST_OK));
    push_row(mk(dla_pkg::ACT_PLANT, 0, 0, 0, 2'b00, 2'b00), 1,
             oc(0, 0, 0, 0, dla_pkg::ST_OK));
    push_row(mk(dla_pkg::ACT_ADD, 0, 255, 0, 2'b00, 2'b00), 1,
             oc(255, 0, 0, 1, dla_pkg::ST_OK));
    push_row(mk(dla_pkg::ACT_ADD, 0, 0, 255, 2'b00, 2'b00), 1,
             oc(0, 255, 0, 2, dla_pkg::ST_OK));
    push_row(mk(dla_pkg::ACT_ADD, 0, 128, 128, 2'b00, 2'b00), 1,
             oc(128, 128, 0, 3, dla_pkg::ST_OK));
    push_row(mk(dla_pkg::ACT_STEP, 0, 0, 0, 2'b01, 2'b11), 0, '0);
    push_row(mk(dla_pkg::ACT_STEP, 1, 0, 0, 2'b10, 2'b01), 0, '0);
    push_row(mk(dla_pkg::ACT_STEP, 2, 0, 0, 2'b00, 2'b00), 0, '0);
    push_row(mk(dla_pkg::ACT_PLANT, 0, 129, 129, 2'b00, 2'b00), 0, '0);
    push_row(mk(dla_pkg::ACT_STEP, 2, 0, 0, 2'b00, 2'b00), 0, '0);
    push_row(mk(dla_pkg::ACT_STEP, 1023, 0, 0, 2'b01, 2'b01), 1,
             oc(0, 0, 0, 2, dla_pkg::ST_NO_SLOT));
    push_row(mk(dla_pkg::ACT_ADD, 0, 200, 200, 2'b00, 2'b00), 0, '0);
    push_row(mk(dla_pkg::ACT_PLANT, 0, 202, 202, 2'b00, 2'b00), 0, '0);
    push_row(mk(dla_pkg::ACT_STEP, 2, 0, 0, 2'b01, 2'b01), 0, '0);
    // out-of-range sizes: zero width acts as one, oversized height as full
    push_cfg(dla_pkg::REG_WIDTH, 9'd0);
    push_cfg(dla_pkg::REG_HEIGHT, 9'd511);
    push_row(mk(dla_pkg::ACT_PLANT, 0, 1, 0, 2'b00, 2'b00), 1,
             oc(1, 0, 0, 2, dla_pkg::ST_OFF));
    push_row(mk(dla_pkg::ACT_ADD, 0, 5, 3, 2'b00, 2'b00), 1,
             oc(5, 3, 0, 2, dla_pkg::ST_OFF));
    push_row(mk(dla_pkg::ACT_STEP, 0, 0, 0, 2'b00, 2'b00), 0, '0);
    push_row(mk(dla_pkg::ACT_STEP, 0, 0, 0, 2'b11, 2'b10), 0, '0);
    push_cfg(dla_pkg::REG_WIDTH, 9'd256);
    push_cfg(dla_pkg::REG_HEIGHT, 9'd256);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain();
        write_reg(directed_rows[i].cfg_reg, directed_rows[i].cfg_val);
      end else begin
        issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    run_phase(9'd16, 9'd16, 60);
    run_phase(9'd1, 9'd1, 15);
    run_phase(9'd3, 9'd200, 25);

    // fill the list to capacity, then a few adds that must be refused
    drain();
    write_reg(dla_pkg::REG_WIDTH, 9'd256);
    write_reg(dla_pkg::REG_HEIGHT, 9'd256);
    while (walkers < PARTS + 3) begin
      r = mk(dla_pkg::ACT_ADD, int'($urandom_range(1023)), int'($urandom_range(255)),
             int'($urandom_range(255)), 2'($urandom_range(3)), 2'($urandom_range(3)));
      issue(r, 1'b0, '0);
      if (walkers == PARTS) break;
    end
    for (int i = 0; i < 3; i++) begin
      issue(mk(dla_pkg::ACT_ADD, 0, 7, 7, 2'b00, 2'b00), 1'b0, '0);
    end
    issue(mk(dla_pkg::ACT_STEP, 1023, 0, 0, 2'b01, 2'b10), 1'b0, '0);

    run_phase(9'd256, 9'd1, 15);
    run_phase(9'd40, 9'd40, 30);
    calm = 1'b1;
    run_phase(9'd12, 9'd9, 25);

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
